FILE: sv/derivative_instruction_expander_assert.svh
// Assertion macros for the derivative instruction expander.
// Used by the top level; relies on clk and rst being visible where expanded.
`ifndef DERIVATIVE_INSTRUCTION_EXPANDER_ASSERT_SVH
`define DERIVATIVE_INSTRUCTION_EXPANDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DIE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DIE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DIE_ASSERT_ALWAYS(lbl, cond, msg)
`define DIE_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DIE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/die_pkg.sv
// Shared types and codes for the derivative instruction expander.
// Used by die_expand_row and derivative_instruction_expander; no dependencies.
package die_pkg;

  typedef enum logic [3:0] {
    OP_LOADID   = 4'd0,
    OP_LOADREAL = 4'd1,
    OP_LOADINT  = 4'd2,
    OP_NEG      = 4'd3,
    OP_ADD      = 4'd4,
    OP_SUB      = 4'd5,
    OP_MUL      = 4'd6,
    OP_DIV      = 4'd7,
    OP_POW      = 4'd8,
    OP_CALL0    = 4'd9,
    OP_CALL1    = 4'd10
  } die_op_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OPCODE   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_MAP_LOAD  = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STMT_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CONST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_CONST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_SYMBOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRT_SYMBOL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE  = 3'd5;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_MAX = 4'd9;

  typedef struct packed {
    logic        action;
    logic [3:0]  opcode;
    logic [15:0] dest_reg;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_opcode;
    logic [15:0] out_dest;
    logic [15:0] out_operand_a;
    logic [15:0] out_operand_b;
    logic        last;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [10:0] stmt_offset;
    logic [15:0] zero_const_index;
    logic [15:0] one_const_index;
    logic [7:0]  log_symbol_index;
    logic [7:0]  wrt_symbol_index;
    logic [15:0] first_free_register;
  } cfg_t;

  typedef struct packed {
    logic room_one;
    logic room_pow;
  } room_t;

  typedef struct packed {
    logic       done;
    logic       halt;
    logic [3:0] temp_inc;
  } step_t;

endpackage

FILE: sv/die_expand_row.sv
// Builds one emitted row of the derivative expansion for a given step.
// Depends on die_pkg for the item, configuration and status types.
module die_expand_row (
  input  die_pkg::in_item_t          item,
  input  logic [die_pkg::STEP_W-1:0] step_idx,
  input  die_pkg::cfg_t              cfg,
  input  logic [15:0]                tbase,
  input  logic [7:0]                 map_sym,
  input  die_pkg::room_t             room,
  output die_pkg::out_item_t         row,
  output die_pkg::step_t             status
);
  import die_pkg::*;

  logic [15:0] d_dest_reg;
  logic [15:0] d_a_reg;
  logic [15:0] d_b_reg;
  logic [15:0] t0, t1, t2, t3, t4, t5, t6, t7;
  logic [3:0]  d_op;
  logic [15:0] d_dest;
  logic [15:0] d_a;
  logic [15:0] d_b;
  logic        d_last;
  logic        valid_op;
  logic        need_pow_room;
  logic [3:0]  inc;

  assign d_dest_reg = item.dest_reg + 16'(cfg.stmt_offset);
  assign d_a_reg    = item.operand_a + 16'(cfg.stmt_offset);
  assign d_b_reg    = item.operand_b + 16'(cfg.stmt_offset);
  assign t0 = tbase;
  assign t1 = tbase + 16'd1;
  assign t2 = tbase + 16'd2;
  assign t3 = tbase + 16'd3;
  assign t4 = tbase + 16'd4;
  assign t5 = tbase + 16'd5;
  assign t6 = tbase + 16'd6;
  assign t7 = tbase + 16'd7;

  always_comb begin
    d_op          = OP_LOADREAL;
    d_dest        = d_dest_reg;
    d_a           = '0;
    d_b           = '0;
    d_last        = 1'b0;
    valid_op      = 1'b1;
    need_pow_room = 1'b0;
    inc           = 4'd0;
    case (item.opcode)
      OP_LOADID: begin
        d_a    = (item.operand_a == {8'd0, cfg.wrt_symbol_index}) ?
                 cfg.one_const_index : cfg.zero_const_index;
        d_last = 1'b1;
      end
      OP_LOADREAL, OP_LOADINT, OP_CALL0: begin
        d_a    = cfg.zero_const_index;
        d_last = 1'b1;
      end
      OP_NEG: begin
        d_op   = OP_NEG;
        d_a    = d_a_reg;
        d_last = 1'b1;
      end
      OP_ADD, OP_SUB: begin
        d_op   = item.opcode;
        d_a    = d_a_reg;
        d_b    = d_b_reg;
        d_last = 1'b1;
      end
      OP_MUL: begin
        inc = 4'd1;
        case (step_idx)
          4'd1: begin
            d_op = OP_MUL; d_dest = t0; d_a = item.operand_a; d_b = d_b_reg;
          end
          4'd2: begin
            d_op = OP_MUL; d_a = d_a_reg; d_b = item.operand_b;
          end
          default: begin
            d_op = OP_ADD; d_a = t0; d_b = d_dest_reg; d_last = 1'b1;
          end
        endcase
      end
      OP_DIV: begin
        inc = 4'd1;
        case (step_idx)
          4'd1: begin
            d_op = OP_DIV; d_dest = t0; d_a = d_a_reg; d_b = item.operand_b;
          end
          4'd2: begin
            d_op = OP_DIV; d_a = d_b_reg; d_b = item.operand_b;
          end
          4'd3: begin
            d_op = OP_MUL; d_a = item.dest_reg; d_b = d_dest_reg;
          end
          default: begin
            d_op = OP_SUB; d_a = t0; d_b = d_dest_reg; d_last = 1'b1;
          end
        endcase
      end
      OP_POW: begin
        inc           = 4'd8;
        need_pow_room = (step_idx == 4'd1);
        case (step_idx)
          4'd1: begin
            d_op = OP_CALL1; d_dest = t0;
            d_a = {8'd0, cfg.log_symbol_index}; d_b = item.operand_a;
          end
          4'd2: begin
            d_op = OP_MUL; d_dest = t1; d_a = d_b_reg; d_b = t0;
          end
          4'd3: begin
            d_op = OP_MUL; d_dest = t2; d_a = t1; d_b = item.dest_reg;
          end
          4'd4: begin
            d_op = OP_MUL; d_dest = t3; d_a = item.operand_b; d_b = d_a_reg;
          end
          4'd5: begin
            d_op = OP_LOADREAL; d_dest = t4;
            d_a = cfg.one_const_index; d_b = cfg.one_const_index;
          end
          4'd6: begin
            d_op = OP_SUB; d_dest = t5; d_a = item.operand_b; d_b = t4;
          end
          4'd7: begin
            d_op = OP_POW; d_dest = t6; d_a = item.operand_a; d_b = t5;
          end
          4'd8: begin
            d_op = OP_MUL; d_dest = t7; d_a = t3; d_b = t6;
          end
          default: begin
            d_op = OP_ADD; d_a = t2; d_b = t7; d_last = 1'b1;
          end
        endcase
      end
      OP_CALL1: begin
        inc = 4'd1;
        case (step_idx)
          4'd1: begin
            d_op = OP_CALL1; d_dest = t0; d_a = {8'd0, map_sym}; d_b = item.operand_b;
          end
          default: begin
            d_op = OP_MUL; d_a = t0; d_b = d_b_reg; d_last = 1'b1;
          end
        endcase
      end
      default: begin
        valid_op = 1'b0;
      end
    endcase
  end

  always_comb begin
    row             = '0;
    status          = '0;
    status.temp_inc = inc;
    if (step_idx == '0) begin
      if (!room.room_one) begin
        row.last        = 1'b1;
        row.error_code  = ERR_OVERFLOW;
        status.done     = 1'b1;
        status.halt     = 1'b1;
      end else begin
        row.out_opcode    = item.opcode;
        row.out_dest      = item.dest_reg;
        row.out_operand_a = item.operand_a;
        row.out_operand_b = item.operand_b;
      end
    end else if (!valid_op) begin
      row.last       = 1'b1;
      row.error_code = ERR_OPCODE;
      status.done    = 1'b1;
      status.halt    = 1'b1;
    end else if (!(need_pow_room ? room.room_pow : room.room_one)) begin
      row.last       = 1'b1;
      row.error_code = ERR_OVERFLOW;
      status.done    = 1'b1;
      status.halt    = 1'b1;
    end else begin
      row.out_opcode    = d_op;
      row.out_dest      = d_dest;
      row.out_operand_a = d_a;
      row.out_operand_b = d_b;
      row.last          = d_last;
      status.done       = d_last;
    end
  end

endmodule

FILE: sv/derivative_instruction_expander.sv
// Top level of the derivative instruction expander: front stages, map memory and sequencer.
// Depends on die_pkg, die_expand_row and derivative_instruction_expander_assert.svh.
// A translate transfer yields one emitted instruction per clock while result_ready allows:
// the original instruction, then its derivative instructions (2 to 10 rows in all, or the
// error row that halts the block), and an item holds the sequencer until its last row. Map
// loads and translates arriving while halted pass through it and emit nothing. Items enter
// through a two-stage front end (map index reduction, then the synchronous map memory read or
// write), so the first row of an item appears only after both stages, while the next item
// is accepted and prepared during the current expansion. The single output register, fed one
// row per cycle while result_ready allows, sets the rate. The map needs no clearing pass.
`include "derivative_instruction_expander_assert.svh"

module derivative_instruction_expander #(
  parameter int MAP_ENTRIES    = 256,
  parameter int MAX_STMT_INDEX = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  die_pkg::in_item_t                 item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output die_pkg::out_item_t                result,
  input  logic                              cfg_write,
  input  logic [die_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);
  import die_pkg::*;

  localparam int MAP_AW = $clog2(MAP_ENTRIES);
  localparam int RW     = 34 - MAP_AW;
  localparam int QW     = RW - 16;
  localparam logic [RW-1:0] MAP_RECIP = RW'((64'd1 << 32) / MAP_ENTRIES + 1);
  localparam int ECW    = $clog2(MAX_STMT_INDEX + 2);

  cfg_t                 cfg;
  logic                 s0_valid;
  in_item_t             s0_item;
  logic [QW-1:0]        s0_q;
  logic                 s1_valid;
  in_item_t             s1_item;
  logic [7:0]           map_rdata;
  logic [7:0]           deriv_map [MAP_ENTRIES];
  logic [STEP_W-1:0]    step_idx;
  logic [ECW-1:0]       emitted_count;
  logic [15:0]          temp_count;
  logic                 halted;

  logic [RW+15:0]       map_prod;
  logic [15:0]          q_times_m;
  logic [15:0]          map_index_full;
  logic [MAP_AW-1:0]    map_addr;
  logic                 res_free;
  logic                 emit;
  logic                 s1_skip;
  logic                 s1_done;
  logic                 s1_take;
  logic                 s0_move;
  logic [15:0]          tbase;
  room_t                room;
  out_item_t            row;
  step_t                status;

  assign map_prod       = (RW+16)'(item.operand_a) * (RW+16)'(MAP_RECIP);
  assign q_times_m      = 16'(s0_q) * 16'(MAP_ENTRIES);
  assign map_index_full = s0_item.operand_a - q_times_m;
  assign map_addr       = map_index_full[MAP_AW-1:0];

  assign res_free   = !result_valid || result_ready;
  assign s1_skip    = s1_valid && ((s1_item.action == ACT_MAP_LOAD) || halted);
  assign emit       = s1_valid && (s1_item.action == ACT_TRANSLATE) && !halted && res_free;
  assign s1_done    = s1_skip || (emit && status.done);
  assign s1_take    = !s1_valid || s1_done;
  assign s0_move    = s0_valid && s1_take;
  assign item_ready = !s0_valid || s1_take;

  assign tbase         = cfg.first_free_register + temp_count;
  assign room.room_one = (emitted_count <= ECW'(MAX_STMT_INDEX));
  assign room.room_pow = ({1'b0, emitted_count} + (ECW+1)'(8)) <= (ECW+1)'(MAX_STMT_INDEX);

  die_expand_row u_row (
    .item     (s1_item),
    .step_idx (step_idx),
    .cfg      (cfg),
    .tbase    (tbase),
    .map_sym  (map_rdata),
    .room     (room),
    .row      (row),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (s0_move) begin
      if (s0_item.action == ACT_MAP_LOAD) begin
        deriv_map[map_addr] <= s0_item.operand_b[7:0];
      end else begin
        map_rdata <= deriv_map[map_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      s0_item <= item;
      s0_q    <= map_prod[RW+15:32];
    end
    if (s0_move) begin
      s1_item <= s0_item;
    end
    if (emit) begin
      result <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid      <= 1'b0;
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
      step_idx      <= '0;
      emitted_count <= '0;
      temp_count    <= '0;
      halted        <= 1'b0;
      cfg.stmt_offset         <= '0;
      cfg.zero_const_index    <= '0;
      cfg.one_const_index     <= 16'd1;
      cfg.log_symbol_index    <= '0;
      cfg.wrt_symbol_index    <= '0;
      cfg.first_free_register <= '0;
    end else begin
      if (item_ready) begin
        s0_valid <= item_valid;
      end
      if (s1_take) begin
        s1_valid <= s0_valid;
      end
      if (res_free) begin
        result_valid <= emit;
      end
      if (s1_done) begin
        step_idx <= '0;
      end else if (emit) begin
        step_idx <= step_idx + 4'd1;
      end
      if (emit && (row.error_code == ERR_NONE)) begin
        emitted_count <= emitted_count + ECW'(1);
      end
      if (emit && status.done && !status.halt) begin
        temp_count <= temp_count + 16'(status.temp_inc);
      end
      if (emit && status.halt) begin
        halted <= 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_STMT_OFFSET: cfg.stmt_offset         <= cfg_data[10:0];
          CFG_ZERO_CONST:  cfg.zero_const_index    <= cfg_data;
          CFG_ONE_CONST:   cfg.one_const_index     <= cfg_data;
          CFG_LOG_SYMBOL:  cfg.log_symbol_index    <= cfg_data[7:0];
          CFG_WRT_SYMBOL:  cfg.wrt_symbol_index    <= cfg_data[7:0];
          CFG_FIRST_FREE:  cfg.first_free_register <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  `DIE_ASSERT_ALWAYS(a_count_bound, emitted_count <= ECW'(MAX_STMT_INDEX + 1), "Statement count beyond limit")
  `DIE_ASSERT_ALWAYS(a_step_bound, step_idx <= STEP_MAX, "Expansion step out of range")
  `DIE_ASSERT_NEXT(a_halt_sticky, halted, halted, "Halt cleared without reset")
  `DIE_ASSERT_NEXT(a_error_halts, emit && status.halt, halted, "Error row did not halt the block")
  `DIE_ASSERT_IMPLIES(a_error_last, result_valid && (result.error_code != ERR_NONE), result.last, "Error row not marked last")

endmodule
